[design/swfr_pkg.sv]
// Package with the constants and types shared by the sliding-window frame receiver.
`default_nettype none

package swfr_pkg;

  // Window geometry and framing characters.
  localparam int unsigned WINDOW_BYTES = 22;
  localparam int unsigned FILL_W       = 5;
  localparam logic [7:0]  START_MARK   = 8'h40;  // '@'
  localparam logic [7:0]  END_MARK     = 8'h2B;  // '+'
  localparam logic [7:0]  SUM_SEED     = 8'd19;

  // Offsets of the frame fields inside the window.
  localparam int unsigned SUM_AT     = 1;
  localparam int unsigned ID_AT      = 2;
  localparam int unsigned MODE_AT    = 3;
  localparam int unsigned AUX_AT     = 4;
  localparam int unsigned WORD_ONE   = 5;
  localparam int unsigned WORD_TWO   = 9;
  localparam int unsigned WORD_THREE = 13;
  localparam int unsigned WORD_FOUR  = 17;
  localparam int unsigned SUM_LAST   = 20;

  // One decoded frame.
  typedef struct packed {
    logic [7:0]  frame_mode;
    logic [7:0]  frame_aux;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic [31:0] word_four;
  } result_t;

  // Status of the result queue as seen by the back end and the top level.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

[design/swfr_ifs.sv]
// Channel interfaces of the frame receiver: byte input, frame output and configuration write.
`default_nettype none

interface swfr_in_if import swfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swfr_out_if import swfr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  frame_mode;
  logic [7:0]  frame_aux;
  logic [31:0] word_one;
  logic [31:0] word_two;
  logic [31:0] word_three;
  logic [31:0] word_four;

  modport source (output valid, output frame_mode, output frame_aux, output word_one,
                  output word_two, output word_three, output word_four, input ready);
  modport sink   (input valid, input frame_mode, input frame_aux, input word_one,
                  input word_two, input word_three, input word_four, output ready);
endinterface

interface swfr_cfg_if import swfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/swfr_front.sv]
// Front end: byte window, fill count, station id register and frame check.
`default_nettype none

module swfr_front import swfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  output logic            push,
  output result_t         push_data
);

  logic [7:0]        window_r [WINDOW_BYTES];
  logic [7:0]        window_nxt [WINDOW_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [7:0]        station_id_r;
  logic              full;
  logic [7:0]        sum;
  logic              pass;

  assign full = (fill_r >= FILL_W'(WINDOW_BYTES));

  // Next window: append at the fill position, or shift left once the window is full.
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (full) begin
        window_nxt[i] = (i == WINDOW_BYTES - 1) ? in_byte : window_r[(i + 1) % WINDOW_BYTES];
      end else begin
        window_nxt[i] = (fill_r == FILL_W'(i)) ? in_byte : window_r[i];
      end
    end
  end

  // Checksum over the frame body of the updated window, stale bytes included.
  always_comb begin
    sum = SUM_SEED;
    for (int i = MODE_AT; i <= SUM_LAST; i++) begin
      sum = sum ^ window_nxt[i];
    end
  end

  assign pass = (in_byte == END_MARK) && (window_nxt[0] == START_MARK) &&
                (sum == window_nxt[SUM_AT]) && (window_nxt[ID_AT] == station_id_r);

  // A passing frame restarts the fill; otherwise the count saturates at the window size.
  always_comb begin
    if (pass) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = FILL_W'(WINDOW_BYTES);
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  // Result fields straight from the updated window.
  assign push = in_accept && pass;
  always_comb begin
    push_data.frame_mode = window_nxt[MODE_AT];
    push_data.frame_aux  = window_nxt[AUX_AT];
    push_data.word_one   = {window_nxt[WORD_ONE+3], window_nxt[WORD_ONE+2],
                            window_nxt[WORD_ONE+1], window_nxt[WORD_ONE]};
    push_data.word_two   = {window_nxt[WORD_TWO+3], window_nxt[WORD_TWO+2],
                            window_nxt[WORD_TWO+1], window_nxt[WORD_TWO]};
    push_data.word_three = {window_nxt[WORD_THREE+3], window_nxt[WORD_THREE+2],
                            window_nxt[WORD_THREE+1], window_nxt[WORD_THREE]};
    push_data.word_four  = {window_nxt[WORD_FOUR+3], window_nxt[WORD_FOUR+2],
                            window_nxt[WORD_FOUR+1], window_nxt[WORD_FOUR]};
  end

  // Window, fill count and station id registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        window_r[i] <= '0;
      end
      fill_r       <= '0;
      station_id_r <= '0;
    end else begin
      if (in_accept) begin
        window_r <= window_nxt;
        fill_r   <= fill_nxt;
      end
      if (cfg_we) begin
        station_id_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

[design/swfr_queue.sv]
// Two-entry result queue between the frame check and the output stage.
`default_nettype none

module swfr_queue import swfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire result_t  push_data,
  input  wire logic     pop,
  output result_t       pop_data,
  output q_stat_t       stat
);

  result_t    mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign stat.full      = (count_r == 2'd2);
  assign stat.not_empty = (count_r != 2'd0);
  assign pop_data       = mem[rd_ptr_r];

  // Occupancy follows the push and pop of each cycle.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[design/swfr_back.sv]
// Back end: output register that drains the result queue onto the frame channel.
`default_nettype none

module swfr_back import swfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_stat_t  q_stat,
  input  wire result_t  q_data,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output result_t       out_data
);

  logic    out_valid_r;
  result_t out_data_r;

  // Load a new frame whenever the register is empty or is being taken.
  assign pop       = q_stat.not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= q_stat.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= q_data;
    end
  end

endmodule

`default_nettype wire

[design/sliding_window_frame_receiver.sv]
// Top level of the sliding-window frame receiver.
//
// Channels: in_ch carries one received byte per transaction, out_ch carries one
// decoded frame (mode, aux and four little-endian words) per transaction, and
// cfg_ch writes the station id byte; cfg_ch is always ready.
// Each accepted byte enters a 22-byte window in the cycle it is accepted. When it
// is '+' and the window starts with '@', the checksum and station id are checked
// in that same cycle, and a passing frame is written into a two-entry queue.
// The queue is written at the edge that accepts the closing byte, and the frame is
// offered on out_ch once the output register has loaded it from the queue. in_ch
// takes one byte per cycle while the queue is not full, as the window update
// and check are combinational; frames may leave one per cycle while out_ch is ready.
// When out_ch stalls, frames collect in the queue and the output register;
// in_ch drops ready only while the queue holds two frames.
// Reset (rst_n low at a clock edge) clears the window to zeros, the fill count,
// the station id and all queued frames.
`default_nettype none

module sliding_window_frame_receiver import swfr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swfr_in_if.sink    in_ch,
  swfr_out_if.source out_ch,
  swfr_cfg_if.sink   cfg_ch
);

  logic    in_accept;
  logic    push;
  result_t push_data;
  logic    pop;
  result_t pop_data;
  q_stat_t q_stat;
  result_t out_data;

  assign in_ch.ready  = !q_stat.full;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  swfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .push      (push),
    .push_data (push_data)
  );

  swfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  swfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Output payload fields.
  assign out_ch.frame_mode = out_data.frame_mode;
  assign out_ch.frame_aux  = out_data.frame_aux;
  assign out_ch.word_one   = out_data.word_one;
  assign out_ch.word_two   = out_data.word_two;
  assign out_ch.word_three = out_data.word_three;
  assign out_ch.word_four  = out_data.word_four;

  // The queue is never written while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("result queue written while full");

  // Only a closing byte can produce a frame.
  a_push_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_accept && in_ch.rx_byte == END_MARK))
    else $error("frame produced by a byte other than the end mark");

  // A full queue always has a frame waiting at the output in the next cycle.
  a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |=> out_ch.valid)
    else $error("queue full but output register empty");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window frame receiver with a frame scoreboard.
module testbench;
  import swfr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int LIMIT        = 200000;
  localparam int SETTLE       = 8;
  localparam int PHASE_BYTES  = 300;
  localparam int PHASE_FRAMES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 100;

  // Tracks the receive window and station id, and holds the frames still due on the output.
  class frame_scoreboard;
    logic [7:0]  rx_window [WINDOW_BYTES];
    int unsigned rx_fill;
    logic [7:0]  station;
    result_t     frames_due [$];
    int          frames_predicted;
    int          mismatches;

    function new();
      foreach (rx_window[i]) rx_window[i] = 8'h00;
      rx_fill          = 0;
      station          = 8'h00;
      frames_predicted = 0;
      mismatches       = 0;
    endfunction

    function void set_station(logic [7:0] id);
      station = id;
    endfunction

    function logic [31:0] word_at(int unsigned at);
      return {rx_window[at + 3], rx_window[at + 2], rx_window[at + 1], rx_window[at]};
    endfunction

    // Applies one accepted byte to the window and queues a frame if the check passes.
    function void note_byte(logic [7:0] b);
      logic [7:0] sum;
      result_t    frame;
      if (rx_fill >= WINDOW_BYTES) begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++) rx_window[i] = rx_window[i + 1];
        rx_window[WINDOW_BYTES - 1] = b;
      end else begin
        rx_window[rx_fill] = b;
        rx_fill++;
      end
      if (b != END_MARK || rx_window[0] != START_MARK) return;
      sum = SUM_SEED;
      for (int i = MODE_AT; i <= SUM_LAST; i++) sum ^= rx_window[i];
      if (sum != rx_window[SUM_AT] || rx_window[ID_AT] != station) return;
      // A good frame restarts the fill; the window contents stay.
      rx_fill          = 0;
      frame.frame_mode = rx_window[MODE_AT];
      frame.frame_aux  = rx_window[AUX_AT];
      frame.word_one   = word_at(WORD_ONE);
      frame.word_two   = word_at(WORD_TWO);
      frame.word_three = word_at(WORD_THREE);
      frame.word_four  = word_at(WORD_FOUR);
      frames_due.push_back(frame);
      frames_predicted++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Compares one output transaction with the oldest frame still due.
    task check_frame(result_t got);
      result_t want;
      if (frames_due.size() == 0) begin
        report_mismatch("frame received while none was expected");
        return;
      end
      want = frames_due.pop_front();
      check_field("frame_mode", got.frame_mode, want.frame_mode);
      check_field("frame_aux", got.frame_aux, want.frame_aux);
      check_field("word_one", got.word_one, want.word_one);
      check_field("word_two", got.word_two, want.word_two);
      check_field("word_three", got.word_three, want.word_three);
      check_field("word_four", got.word_four, want.word_four);
    endtask

    task check_drained();
      if (frames_due.size() != 0)
        report_mismatch($sformatf("%0d expected frames never arrived", frames_due.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  swfr_in_if  in_ch ();
  swfr_out_if out_ch ();
  swfr_cfg_if cfg_ch ();

  sliding_window_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;
  int cycle_count;
  logic [7:0] frame_buf [WINDOW_BYTES];

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Output ready: a long hold-off when requested, otherwise random stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every output transaction is checked against the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_frame(result_t'({out_ch.frame_mode, out_ch.frame_aux, out_ch.word_one,
                                out_ch.word_two, out_ch.word_three, out_ch.word_four}));
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one byte after random idle cycles and waits for the transaction.
  task automatic send_byte(logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    sb.note_byte(b);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits for every due frame, then lets the pipeline settle.
  task automatic wait_drained();
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_station(logic [7:0] id);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= id;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_station(id);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random byte with extra weight on the extremes and the framing characters.
  function automatic logic [7:0] pick_byte();
    int unsigned r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    if (r < 20) return START_MARK;
    if (r < 24) return END_MARK;
    return 8'($urandom_range(255));
  endfunction

  // Adds start mark, checksum, id and end mark around the payload in frame_buf.
  function automatic void build_frame(logic [7:0] id);
    logic [7:0] sum;
    sum = SUM_SEED;
    for (int i = MODE_AT; i <= SUM_LAST; i++) sum ^= frame_buf[i];
    frame_buf[0]                = START_MARK;
    frame_buf[SUM_AT]           = sum;
    frame_buf[ID_AT]            = id;
    frame_buf[WINDOW_BYTES - 1] = END_MARK;
  endfunction

  // Sends frame_buf, optionally dropping one byte or inserting a stray one.
  task automatic send_frame_bytes(int drop_at, int extra_at);
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (i != drop_at) send_byte(frame_buf[i]);
      if (i == extra_at) send_byte(pick_byte());
    end
  endtask

  // Mostly well-formed frames with random payload, plus corrupted frames and noise.
  task automatic run_random(int pause_at);
    int start_bytes;
    int start_frames;
    int blocks;
    int kind;
    start_bytes  = bytes_sent;
    start_frames = sb.frames_predicted;
    blocks       = 0;
    while ((bytes_sent - start_bytes < PHASE_BYTES ||
            sb.frames_predicted - start_frames < PHASE_FRAMES) &&
           bytes_sent - start_bytes < 4 * PHASE_BYTES) begin
      if (blocks == pause_at) begin
        stop_sending();
        wait_drained();
      end
      kind = $urandom_range(99);
      if (kind < 93) begin
        for (int i = MODE_AT; i <= SUM_LAST; i++) frame_buf[i] = pick_byte();
        build_frame(sb.station);
        if (kind >= 86) begin
          if ($urandom_range(1) == 1) send_frame_bytes($urandom_range(WINDOW_BYTES - 1), -1);
          else send_frame_bytes(-1, $urandom_range(WINDOW_BYTES - 1));
        end else begin
          if (kind >= 78) frame_buf[ID_AT] ^= 8'($urandom_range(1, 255));
          else if (kind >= 70) frame_buf[SUM_AT] ^= 8'($urandom_range(1, 255));
          send_frame_bytes(-1, -1);
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(pick_byte());
      end
      blocks++;
    end
    stop_sending();
  endtask

  // Reset, directed sequences, then the random phases.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = 8'h00;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short frame over the reset zeros whose id byte mismatches the reset station id.
    send_byte(START_MARK);
    send_byte(SUM_SEED ^ END_MARK);
    send_byte(8'hFF);
    send_byte(END_MARK);
    stop_sending();
    wait_drained();
    write_station(8'hFF);

    // Same partial window: first a checksum failure, then a pass over the zeros.
    send_byte(END_MARK);
    send_byte(END_MARK);

    // Full frame at the byte extremes whose checksum is the end mark itself.
    for (int i = MODE_AT; i <= SUM_LAST; i++) frame_buf[i] = 8'hFF;
    frame_buf[MODE_AT] = 8'hC7;
    build_frame(8'hFF);
    send_frame_bytes(-1, -1);

    // Two bytes that pass again on the stale bytes of the previous frame.
    send_byte(START_MARK);
    send_byte(END_MARK);
    stop_sending();

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_station(8'h00);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          @(posedge clk);
          hold_left = HOLD_CYCLES;
        end
        1: begin
          write_station(8'($urandom_range(1, 254)));
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          write_station(8'hFF);
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          write_station(8'($urandom_range(255)));
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      run_random(p == 3 ? 6 : -1);
    end

    wait_drained();
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
